>>> hdl/idrp_pkg.sv
// ----------------------------------------------------------------------------
// idrp_pkg
// shared types, codes and byte classification for the directory record parser
// ----------------------------------------------------------------------------
package idrp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] MIN_RECORD_LENGTH = 8'd34;
  localparam logic [7:0] NAME_OFFSET       = 8'd33;
  localparam logic [7:0] NAME_LENGTH_POS   = 8'd32;
  localparam logic [7:0] FLAGS_POS         = 8'd25;

  localparam logic [1:0] KIND_FILE  = 2'd0;
  localparam logic [1:0] KIND_DIR   = 2'd1;
  localparam logic [1:0] KIND_DOT   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SHORT     = 3'd1;
  localparam logic [2:0] ERR_CROSS     = 3'd2;
  localparam logic [2:0] ERR_NAME_LONG = 3'd3;
  localparam logic [2:0] ERR_PAD       = 3'd4;
  localparam logic [2:0] ERR_BAD_NAME  = 3'd5;

  typedef struct packed {
    logic [7:0] data;
    logic       sector_end;
    logic       extent_end;
    logic       reserved;
    logic       is_semi;
    logic       is_dot;
    logic       is_space;
    logic [7:0] lowered;
  } byte_info_t;

  function automatic logic is_reserved(input logic [7:0] c);
    is_reserved = (c < 8'h20) || (c > 8'h7e) || (c == 8'h2f) || (c == 8'h5c) ||
                  (c == 8'h3a) || (c == 8'h22) || (c == 8'h3c) || (c == 8'h3e) ||
                  (c == 8'h7c) || (c == 8'h3f) || (c == 8'h2a);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = ((c >= 8'h41) && (c <= 8'h5a)) ? c + 8'd32 : c;
  endfunction

  // letters of "zero"
  function automatic logic [7:0] zero_char(input logic [1:0] idx);
    unique case (idx)
      2'd0: zero_char = 8'h7a;
      2'd1: zero_char = 8'h65;
      2'd2: zero_char = 8'h72;
      2'd3: zero_char = 8'h6f;
      default: zero_char = 8'h00;
    endcase
  endfunction

endpackage

>>> hdl/idrp_front.sv
// ----------------------------------------------------------------------------
// idrp_front
// input stage: takes bytes and classifies them for the record engine
// ----------------------------------------------------------------------------
module idrp_front
  import idrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_stall,
  input  logic [7:0] data_byte,
  input  logic       last_in_sector,
  input  logic       end_of_extent,
  output logic       push_valid,
  input  logic       push_ready,
  output byte_info_t push_item
);

  logic       hold_valid;
  byte_info_t hold_item;
  logic       take;

  assign data_stall = hold_valid && !push_ready;
  assign take       = data_valid && !data_stall;
  assign push_valid = hold_valid;
  assign push_item  = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
    if (take) begin
      hold_item.data       <= data_byte;
      hold_item.sector_end <= last_in_sector;
      hold_item.extent_end <= end_of_extent;
      hold_item.reserved   <= is_reserved(data_byte);
      hold_item.is_semi    <= (data_byte == 8'h3b);
      hold_item.is_dot     <= (data_byte == 8'h2e);
      hold_item.is_space   <= (data_byte == 8'h20);
      hold_item.lowered    <= to_lower(data_byte);
    end
  end

endmodule

>>> hdl/idrp_queue.sv
// ----------------------------------------------------------------------------
// idrp_queue
// short fifo of classified bytes between the input stage and the engine
// ----------------------------------------------------------------------------
module idrp_queue
  import idrp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  byte_info_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output byte_info_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  byte_info_t      slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

>>> hdl/idrp_engine.sv
// ----------------------------------------------------------------------------
// idrp_engine
// record engine: walks record bytes, checks them and registers one entry
// ----------------------------------------------------------------------------
module idrp_engine
  import idrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  byte_info_t  pop_item,
  output logic        entry_valid,
  input  logic        entry_stall,
  output logic [1:0]  entry_kind,
  output logic [2:0]  error_code,
  output logic [31:0] extent_address,
  output logic [31:0] data_length,
  output logic        multi_extent,
  output logic [7:0]  kept_name_length,
  output logic        skip_directory
);

  typedef enum logic [1:0] {
    MODE_START,
    MODE_RECORD,
    MODE_PAD,
    MODE_ERROR
  } mode_t;

  mode_t       mode, mode_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  record_length, record_length_next;
  logic [7:0]  name_length, name_length_next;
  logic [31:0] address_acc, address_acc_next;
  logic [31:0] size_acc, size_acc_next;
  logic [1:0]  flag_bits, flag_bits_next;
  logic        version_seen, version_seen_next;
  logic [7:0]  kept_count, kept_count_next;
  logic [7:0]  last_nondot_len, last_nondot_len_next;
  logic        last_nondot_space, last_nondot_space_next;
  logic        name_invalid, name_invalid_next;
  logic        zero_match, zero_match_next;
  logic [7:0]  first_name_byte, first_name_byte_next;

  logic        fire;
  logic        emit;
  logic        err_hit;
  logic [2:0]  err_val;
  logic [1:0]  res_kind;
  logic [31:0] res_addr;
  logic [31:0] res_len;
  logic        res_multi;
  logic [7:0]  res_kept;
  logic        res_skip;
  logic        stop;
  logic [7:0]  b;
  logic [8:0]  name_end;
  logic [8:0]  p_plus;
  logic [1:0]  lane;
  logic [7:0]  kc;

  assign pop_ready = !entry_valid || !entry_stall;
  assign fire      = pop_valid && pop_ready;
  assign b         = pop_item.data;
  assign stop      = pop_item.sector_end || pop_item.extent_end;
  assign name_end  = 9'd33 + {1'b0, name_length};
  assign p_plus    = {1'b0, byte_position} + 9'd1;
  assign lane      = byte_position[1:0] - 2'd2;

  always_comb begin
    mode_next              = mode;
    byte_position_next     = byte_position;
    record_length_next     = record_length;
    name_length_next       = name_length;
    address_acc_next       = address_acc;
    size_acc_next          = size_acc;
    flag_bits_next         = flag_bits;
    version_seen_next      = version_seen;
    kept_count_next        = kept_count;
    last_nondot_len_next   = last_nondot_len;
    last_nondot_space_next = last_nondot_space;
    name_invalid_next      = name_invalid;
    zero_match_next        = zero_match;
    first_name_byte_next   = first_name_byte;
    emit      = 1'b0;
    err_hit   = 1'b0;
    err_val   = ERR_NONE;
    res_kind  = KIND_FILE;
    res_addr  = '0;
    res_len   = '0;
    res_multi = 1'b0;
    res_kept  = '0;
    res_skip  = 1'b0;
    kc        = kept_count + 8'd1;

    unique case (mode)
      MODE_ERROR: begin
        if (pop_item.extent_end) mode_next = MODE_START;
      end
      MODE_PAD: begin
        if (stop) mode_next = MODE_START;
      end
      MODE_START: begin
        byte_position_next     = '0;
        record_length_next     = '0;
        name_length_next       = '0;
        address_acc_next       = '0;
        size_acc_next          = '0;
        flag_bits_next         = '0;
        version_seen_next      = 1'b0;
        kept_count_next        = '0;
        last_nondot_len_next   = '0;
        last_nondot_space_next = 1'b0;
        name_invalid_next      = 1'b0;
        zero_match_next        = 1'b1;
        first_name_byte_next   = '0;
        if (b == 8'd0) begin
          if (!stop) mode_next = MODE_PAD;
        end else begin
          record_length_next = b;
          if (b < MIN_RECORD_LENGTH) begin
            err_hit = 1'b1;
            err_val = ERR_SHORT;
          end else if (stop) begin
            err_hit = 1'b1;
            err_val = ERR_CROSS;
          end else begin
            byte_position_next = 8'd1;
            mode_next          = MODE_RECORD;
          end
        end
      end
      MODE_RECORD: begin
        priority if (byte_position >= 8'd2 && byte_position <= 8'd5) begin
          address_acc_next[{lane, 3'b000} +: 8] = address_acc[{lane, 3'b000} +: 8] | b;
        end else if (byte_position >= 8'd10 && byte_position <= 8'd13) begin
          size_acc_next[{lane, 3'b000} +: 8] = size_acc[{lane, 3'b000} +: 8] | b;
        end else if (byte_position == FLAGS_POS) begin
          flag_bits_next = {b[7], b[1]};
        end else if (byte_position == NAME_LENGTH_POS) begin
          name_length_next = b;
          if (b > record_length - NAME_OFFSET) begin
            err_hit = 1'b1;
            err_val = ERR_NAME_LONG;
          end else if (!b[0] && ({1'b0, b} + 9'd33 >= {1'b0, record_length})) begin
            err_hit = 1'b1;
            err_val = ERR_PAD;
          end
        end else if (byte_position >= NAME_OFFSET && {1'b0, byte_position} < name_end) begin
          if (byte_position == NAME_OFFSET) first_name_byte_next = b;
          if (pop_item.reserved) name_invalid_next = 1'b1;
          if (pop_item.is_semi) begin
            version_seen_next = 1'b1;
          end else if (!version_seen) begin
            kept_count_next = kc;
            if (!pop_item.is_dot) begin
              last_nondot_len_next   = kc;
              last_nondot_space_next = pop_item.is_space;
            end
            if (kc >= 8'd1 && kc <= 8'd4 &&
                pop_item.lowered != zero_char(kc[1:0] - 2'd1)) begin
              zero_match_next = 1'b0;
            end
          end
        end else if (byte_position >= NAME_OFFSET && {1'b0, byte_position} == name_end &&
                     !name_length[0]) begin
          if (b != 8'd0) begin
            err_hit = 1'b1;
            err_val = ERR_PAD;
          end
        end

        if (!err_hit) begin
          if (p_plus >= {1'b0, record_length}) begin
            mode_next = MODE_START;
            if (name_length_next == 8'd1 && first_name_byte_next <= 8'd1) begin
              emit      = 1'b1;
              res_kind  = KIND_DOT;
              res_addr  = address_acc_next;
              res_len   = size_acc_next;
              res_multi = flag_bits_next[1];
            end else if (name_invalid_next || last_nondot_len_next == 8'd0 ||
                         last_nondot_space_next) begin
              err_hit = 1'b1;
              err_val = ERR_BAD_NAME;
            end else begin
              emit      = 1'b1;
              res_kind  = flag_bits_next[0] ? KIND_DIR : KIND_FILE;
              res_addr  = address_acc_next;
              res_len   = size_acc_next;
              res_multi = flag_bits_next[1];
              res_kept  = last_nondot_len_next;
              res_skip  = flag_bits_next[0] && zero_match_next &&
                          (last_nondot_len_next == 8'd4);
            end
          end else if (stop) begin
            err_hit = 1'b1;
            err_val = ERR_CROSS;
          end else begin
            byte_position_next = p_plus[7:0];
          end
        end
      end
      default: mode_next = MODE_START;
    endcase

    if (err_hit) begin
      emit      = 1'b1;
      res_kind  = KIND_ERROR;
      res_addr  = '0;
      res_len   = '0;
      res_multi = 1'b0;
      res_kept  = '0;
      res_skip  = 1'b0;
      mode_next = pop_item.extent_end ? MODE_START : MODE_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_START;
      byte_position     <= '0;
      record_length     <= '0;
      name_length       <= '0;
      address_acc       <= '0;
      size_acc          <= '0;
      flag_bits         <= '0;
      version_seen      <= 1'b0;
      kept_count        <= '0;
      last_nondot_len   <= '0;
      last_nondot_space <= 1'b0;
      name_invalid      <= 1'b0;
      zero_match        <= 1'b1;
      first_name_byte   <= '0;
      entry_valid       <= 1'b0;
    end else begin
      if (fire) begin
        mode              <= mode_next;
        byte_position     <= byte_position_next;
        record_length     <= record_length_next;
        name_length       <= name_length_next;
        address_acc       <= address_acc_next;
        size_acc          <= size_acc_next;
        flag_bits         <= flag_bits_next;
        version_seen      <= version_seen_next;
        kept_count        <= kept_count_next;
        last_nondot_len   <= last_nondot_len_next;
        last_nondot_space <= last_nondot_space_next;
        name_invalid      <= name_invalid_next;
        zero_match        <= zero_match_next;
        first_name_byte   <= first_name_byte_next;
      end
      if (fire && emit) begin
        entry_valid <= 1'b1;
      end else if (!entry_stall) begin
        entry_valid <= 1'b0;
      end
    end
    if (fire && emit) begin
      entry_kind       <= res_kind;
      error_code       <= err_val;
      extent_address   <= res_addr;
      data_length      <= res_len;
      multi_extent     <= res_multi;
      kept_name_length <= res_kept;
      skip_directory   <= res_skip;
    end
  end

  a_error_mode_silent: assert property (@(posedge clk) disable iff (rst)
    fire && mode == MODE_ERROR |-> !emit)
    else $error("entry emitted while skipping after an error");

  a_code_matches_kind: assert property (@(posedge clk) disable iff (rst)
    entry_valid |-> ((entry_kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code disagrees with entry kind");

  a_error_fields_clear: assert property (@(posedge clk) disable iff (rst)
    entry_valid && entry_kind == KIND_ERROR |->
      extent_address == '0 && data_length == '0 && kept_name_length == '0)
    else $error("error entry carries record fields");

  a_skip_only_dir: assert property (@(posedge clk) disable iff (rst)
    entry_valid && skip_directory |-> entry_kind == KIND_DIR &&
      kept_name_length == 8'd4)
    else $error("skip flag on an entry that is not a directory named zero");

endmodule

>>> hdl/iso9660_dir_record_parser.sv
// ----------------------------------------------------------------------------
// iso9660_dir_record_parser
// parses iso 9660 directory records from a byte stream into entries
// ----------------------------------------------------------------------------
// One byte of directory extent data is taken per cycle, back to back, while
// data_stall is low, and at most one entry comes out per byte, in the cycle
// after the record engine reads that byte. Bytes pass a classifying input
// register and a short fifo (QUEUE_DEPTH deep) before the record engine, so a
// stalled entry output lets up to QUEUE_DEPTH + 1 bytes in before data_stall
// rises; the engine updates its state for every byte it takes, which sets the
// rate of one byte per clock. Zero-length bytes skip to the sector end; after
// an error entry the rest of the extent is dropped.
module iso9660_dir_record_parser
  import idrp_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_in_sector,
  input  logic        end_of_extent,
  output logic        entry_valid,
  input  logic        entry_stall,
  output logic [1:0]  entry_kind,
  output logic [2:0]  error_code,
  output logic [31:0] extent_address,
  output logic [31:0] data_length,
  output logic        multi_extent,
  output logic [7:0]  kept_name_length,
  output logic        skip_directory
);

  logic       push_valid;
  logic       push_ready;
  byte_info_t push_item;
  logic       pop_valid;
  logic       pop_ready;
  byte_info_t pop_item;

  idrp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .data_valid     (data_valid),
    .data_stall     (data_stall),
    .data_byte      (data_byte),
    .last_in_sector (last_in_sector),
    .end_of_extent  (end_of_extent),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  idrp_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  idrp_engine u_engine (
    .clk              (clk),
    .rst              (rst),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_item         (pop_item),
    .entry_valid      (entry_valid),
    .entry_stall      (entry_stall),
    .entry_kind       (entry_kind),
    .error_code       (error_code),
    .extent_address   (extent_address),
    .data_length      (data_length),
    .multi_extent     (multi_extent),
    .kept_name_length (kept_name_length),
    .skip_directory   (skip_directory)
  );

endmodule
